>>> src/l2lf_pkg.sv
// shared types and constants of the l2 mac learning forwarder
package l2lf_pkg;

    // table and port sizing
    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_PORTS     = 16;

    localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;
    localparam logic [4:0]  PORT_CNT_RST = 5'd16;

    // forwarding decision codes
    typedef enum logic [1:0] {
        VERDICT_FORWARD   = 2'd0,
        VERDICT_FLOOD     = 2'd1,
        VERDICT_DROP_UNK  = 2'd2,
        VERDICT_DROP_SAME = 2'd3
    } t_verdict;

    // source learning outcome codes
    typedef enum logic [1:0] {
        LEARN_KNOWN = 2'd0,
        LEARN_NEW   = 2'd1,
        LEARN_MOVED = 2'd2,
        LEARN_FULL  = 2'd3
    } t_learn;

    // input word: one frame header
    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [3:0]  ingress_port;
    } t_header;

    // output word: forwarding and learning result
    typedef struct packed {
        t_verdict    verdict;
        logic [3:0]  egress_port;
        logic [15:0] egress_mask;
        t_learn      learn_event;
    } t_result;

    // lookup status from the table to the decision logic
    typedef struct packed {
        logic       src_hit;
        logic [3:0] src_port;
        logic       dst_hit;
        logic [3:0] dst_port;
        logic       free_ok;
    } t_lookup;

endpackage

>>> src/l2lf_table.sv
// fully associative mac table with parallel match, lowest free slot and learning write
module l2lf_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_upd,
    input  l2lf_pkg::t_header   i_hdr,
    output l2lf_pkg::t_lookup   o_lookup
);

    localparam int N = l2lf_pkg::TABLE_ENTRIES;

    logic [N-1:0] r_valid;
    logic [47:0]  r_addr [N];
    logic [3:0]   r_port [N];

    logic [N-1:0] src_match;
    logic [N-1:0] dst_match;
    logic [N-1:0] free_vec;
    logic [N-1:0] free_onehot;
    logic [3:0]   src_port;
    logic [3:0]   dst_port;
    logic         src_hit;
    logic         do_move;
    logic         do_new;

    // per-entry compare against source and destination
    always_comb begin
        for (int i = 0; i < N; i++) begin
            src_match[i] = r_valid[i] && (r_addr[i] == i_hdr.src_mac);
            dst_match[i] = r_valid[i] && (r_addr[i] == i_hdr.dst_mac);
        end
    end

    // stored port of the matching entry, at most one entry matches
    always_comb begin
        src_port = 4'd0;
        dst_port = 4'd0;
        for (int i = 0; i < N; i++) begin
            src_port = src_port | (r_port[i] & {4{src_match[i]}});
            dst_port = dst_port | (r_port[i] & {4{dst_match[i]}});
        end
    end

    // lowest free entry as a one-hot vector
    assign free_vec    = ~r_valid;
    assign free_onehot = free_vec & (~free_vec + {{(N-1){1'b0}}, 1'b1});

    assign src_hit = |src_match;
    assign do_move = i_upd && src_hit && (src_port != i_hdr.ingress_port);
    assign do_new  = i_upd && !src_hit && (|free_vec);

    assign o_lookup.src_hit  = src_hit;
    assign o_lookup.src_port = src_port;
    assign o_lookup.dst_hit  = |dst_match;
    assign o_lookup.dst_port = dst_port;
    assign o_lookup.free_ok  = |free_vec;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_new) begin
            r_valid <= r_valid | free_onehot;
        end
    end

    // address and port storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (do_new && free_onehot[i]) begin
                r_addr[i] <= i_hdr.src_mac;
                r_port[i] <= i_hdr.ingress_port;
            end else if (do_move && src_match[i]) begin
                r_port[i] <= i_hdr.ingress_port;
            end
        end
    end

endmodule

>>> src/l2lf_decide.sv
// learning outcome and forwarding decision from the table lookup
module l2lf_decide (
    input  l2lf_pkg::t_header   i_hdr,
    input  l2lf_pkg::t_lookup   i_lookup,
    input  logic [4:0]          i_port_cnt,
    output l2lf_pkg::t_result   o_result
);

    localparam logic [4:0] MAX_P = 5'(l2lf_pkg::MAX_PORTS);

    l2lf_pkg::t_learn learn;
    logic [15:0]      flood_mask;

    // learning outcome
    always_comb begin
        if (i_lookup.src_hit) begin
            learn = (i_lookup.src_port == i_hdr.ingress_port) ?
                    l2lf_pkg::LEARN_KNOWN : l2lf_pkg::LEARN_MOVED;
        end else begin
            learn = i_lookup.free_ok ? l2lf_pkg::LEARN_NEW : l2lf_pkg::LEARN_FULL;
        end
    end

    // flood set: active ports except the ingress port
    always_comb begin
        for (int p = 0; p < 16; p++) begin
            flood_mask[p] = (5'(p) < i_port_cnt) && (5'(p) < MAX_P) &&
                            (4'(p) != i_hdr.ingress_port);
        end
    end

    // forwarding decision, with the source just learned visible to the lookup
    always_comb begin
        o_result.learn_event = learn;
        o_result.egress_port = 4'd0;
        o_result.egress_mask = 16'd0;
        if (i_hdr.dst_mac == l2lf_pkg::BCAST_MAC) begin
            o_result.verdict     = l2lf_pkg::VERDICT_FLOOD;
            o_result.egress_mask = flood_mask;
        end else if ((i_hdr.dst_mac == i_hdr.src_mac) &&
                     (learn != l2lf_pkg::LEARN_FULL)) begin
            o_result.verdict = l2lf_pkg::VERDICT_DROP_SAME;
        end else if (!i_lookup.dst_hit) begin
            o_result.verdict = l2lf_pkg::VERDICT_DROP_UNK;
        end else if (i_lookup.dst_port == i_hdr.ingress_port) begin
            o_result.verdict = l2lf_pkg::VERDICT_DROP_SAME;
        end else begin
            o_result.verdict     = l2lf_pkg::VERDICT_FORWARD;
            o_result.egress_port = i_lookup.dst_port;
            o_result.egress_mask = 16'd1 << i_lookup.dst_port;
        end
    end

endmodule

>>> src/l2_mac_learning_forwarder_unit.sv
// top level of the l2 mac learning forwarder: header and result registers around the table
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+------------------------------
//  header   | in        | i_valid / o_stall      | i_hdr   (src, dst, ingress)
//  result   | out       | o_valid / i_stall      | o_result (verdict, egress, learn)
//  config   | in        | i_cfg_we               | i_cfg_wdata (port count)
//
// one header per cycle while the result is not stalled; the header is held in the header
// register and its result in the result register, from which it is taken.
// the table is updated at the same edge the result is registered, so the next
// header already sees it. synchronous reset clears all valid bits and sets the
// port count to 16. a stalled result holds the header register, which then stalls input.
module l2_mac_learning_forwarder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  l2lf_pkg::t_header   i_hdr,
    output logic                o_valid,
    input  logic                i_stall,
    output l2lf_pkg::t_result   o_result,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata
);

    logic               r_s1_valid;
    l2lf_pkg::t_header  r_s1_hdr;
    logic               r_out_valid;
    l2lf_pkg::t_result  r_out;
    logic [4:0]         r_port_cnt;

    logic               out_free;
    logic               s1_adv;
    logic               in_acc;
    l2lf_pkg::t_lookup  lookup;
    l2lf_pkg::t_result  n_out;

    // handshake control
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_cnt <= l2lf_pkg::PORT_CNT_RST;
        end else if (i_cfg_we) begin
            r_port_cnt <= i_cfg_wdata;
        end
    end

    // header register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_hdr <= i_hdr;
        end
    end

    // table lookup and learning
    l2lf_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (s1_adv),
        .i_hdr    (r_s1_hdr),
        .o_lookup (lookup)
    );

    // decision logic
    l2lf_decide u_decide (
        .i_hdr       (r_s1_hdr),
        .i_lookup    (lookup),
        .i_port_cnt  (r_port_cnt),
        .o_result    (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
